[rtl/dtwg_pkg.sv]
// ----------------------------------------------------------------------------
// dtwg_pkg
// Types, constants and table functions shared by the DTMF tone generator.
// ----------------------------------------------------------------------------
package dtwg_pkg;

  localparam int unsigned TableSize = 200;

  localparam int unsigned KeyW      = 8;
  localparam int unsigned DurW      = 16;
  localparam int unsigned TpmW      = 5;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned PhaseW    = 8;
  localparam int unsigned StepW     = 6;
  localparam int unsigned TicksW    = 20;
  localparam int unsigned RomW      = 7;

  localparam logic [TpmW-1:0]    TicksPerMsRst = 5'd10;
  localparam logic [TicksW-1:0]  TicksMax      = 20'hFFFFF;
  localparam logic [SampleW-1:0] RestLevel     = 8'd126;
  localparam logic [RomW-1:0]    RestHalf      = 7'd63;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = 2;
  localparam int unsigned ResCntW  = 3;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [KeyW-1:0]     key_char;
    logic [DurW-1:0]     duration_ms;
  } item_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               is_rest;
    logic               last;
  } result_t;

  // results of one processed item
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  typedef struct packed {
    logic [ResCntW-1:0] count;
    logic               room2;
  } fifo_status_t;

  typedef struct packed {
    logic             ok;
    logic [StepW-1:0] row_step;
    logic [StepW-1:0] col_step;
  } key_dec_t;

  localparam logic [StepW-1:0] RowSteps [4] = '{6'd14, 6'd15, 6'd17, 6'd19};
  localparam logic [StepW-1:0] ColSteps [4] = '{6'd24, 6'd27, 6'd30, 6'd33};

  // round(63*sin(k*pi/100)), k = 0..50
  localparam logic [5:0] QuarterWave [51] = '{
    6'd0,  6'd2,  6'd4,  6'd6,  6'd8,  6'd10, 6'd12, 6'd14, 6'd16, 6'd18,
    6'd19, 6'd21, 6'd23, 6'd25, 6'd27, 6'd29, 6'd30, 6'd32, 6'd34, 6'd35,
    6'd37, 6'd39, 6'd40, 6'd42, 6'd43, 6'd45, 6'd46, 6'd47, 6'd49, 6'd50,
    6'd51, 6'd52, 6'd53, 6'd54, 6'd55, 6'd56, 6'd57, 6'd58, 6'd59, 6'd59,
    6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62, 6'd63, 6'd63, 6'd63, 6'd63,
    6'd63
  };

  // one full sine period folded from the quarter wave
  function automatic logic [RomW-1:0] sine_at(input logic [PhaseW-1:0] idx);
    logic [PhaseW-1:0] q;
    logic              upper;
    logic [5:0]        qw;
    if (idx <= 8'd50) begin
      q = idx;
      upper = 1'b1;
    end else if (idx <= 8'd100) begin
      q = 8'd100 - idx;
      upper = 1'b1;
    end else if (idx <= 8'd150) begin
      q = idx - 8'd100;
      upper = 1'b0;
    end else begin
      q = 8'd200 - idx;
      upper = 1'b0;
    end
    qw = (q <= 8'd50) ? QuarterWave[q[5:0]] : 6'd0;
    return upper ? (RestHalf + RomW'(qw)) : (RestHalf - RomW'(qw));
  endfunction

  function automatic key_dec_t decode_key(input logic [KeyW-1:0] key);
    key_dec_t   d;
    logic [1:0] r;
    logic [1:0] c;
    d.ok = 1'b1;
    r = 2'd0;
    c = 2'd0;
    case (key)
      8'h31: begin r = 2'd0; c = 2'd0; end
      8'h32: begin r = 2'd0; c = 2'd1; end
      8'h33: begin r = 2'd0; c = 2'd2; end
      8'h34: begin r = 2'd1; c = 2'd0; end
      8'h35: begin r = 2'd1; c = 2'd1; end
      8'h36: begin r = 2'd1; c = 2'd2; end
      8'h37: begin r = 2'd2; c = 2'd0; end
      8'h38: begin r = 2'd2; c = 2'd1; end
      8'h39: begin r = 2'd2; c = 2'd2; end
      8'h30: begin r = 2'd3; c = 2'd1; end
      8'h2A: begin r = 2'd3; c = 2'd0; end
      8'h23: begin r = 2'd3; c = 2'd2; end
      8'h41: begin r = 2'd0; c = 2'd3; end
      8'h42: begin r = 2'd1; c = 2'd3; end
      8'h43: begin r = 2'd2; c = 2'd3; end
      8'h44: begin r = 2'd3; c = 2'd3; end
      default: begin
        d.ok = 1'b0;
      end
    endcase
    d.row_step = RowSteps[r];
    d.col_step = ColSteps[c];
    return d;
  endfunction

endpackage

[rtl/dtwg_in_if.sv]
// ----------------------------------------------------------------------------
// dtwg_in_if
// Item channel into the tone generator: ticks and tone starts.
// ----------------------------------------------------------------------------
interface dtwg_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [dtwg_pkg::KeyW-1:0]   key_char;
  logic [dtwg_pkg::DurW-1:0]   duration_ms;

  modport source (output valid, output opcode, output key_char, output duration_ms,
                  input ready);
  modport sink   (input valid, input opcode, input key_char, input duration_ms,
                  output ready);
endinterface

[rtl/dtwg_out_if.sv]
// ----------------------------------------------------------------------------
// dtwg_out_if
// Sample channel out of the tone generator.
// ----------------------------------------------------------------------------
interface dtwg_out_if;
  logic                          valid;
  logic                          ready;
  logic [dtwg_pkg::SampleW-1:0]  sample;
  logic                          is_rest;
  logic                          last;

  modport source (output valid, output sample, output is_rest, output last,
                  input ready);
  modport sink   (input valid, input sample, input is_rest, input last,
                  output ready);
endinterface

[rtl/dtwg_cfg_if.sv]
// ----------------------------------------------------------------------------
// dtwg_cfg_if
// Write channel for the ticks-per-millisecond register.
// ----------------------------------------------------------------------------
interface dtwg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dtwg_pkg::TpmW-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dtwg_core.sv]
// ----------------------------------------------------------------------------
// dtwg_core
// Tone state, key decode, dual phase accumulators and sample sum.
// ----------------------------------------------------------------------------
module dtwg_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  dtwg_pkg::item_t            item_i,
  input  logic [dtwg_pkg::TpmW-1:0]  tpm_i,
  output dtwg_pkg::res_pair_t        res_o
);

  logic [dtwg_pkg::PhaseW-1:0] row_phase_q, row_phase_d;
  logic [dtwg_pkg::PhaseW-1:0] col_phase_q, col_phase_d;
  logic [dtwg_pkg::StepW-1:0]  row_step_q, row_step_d;
  logic [dtwg_pkg::StepW-1:0]  col_step_q, col_step_d;
  logic [dtwg_pkg::TicksW-1:0] ticks_q, ticks_d;
  logic                        active_q, active_d;

  dtwg_pkg::key_dec_t          dec;
  logic [dtwg_pkg::TicksW:0]   total_full;
  logic [dtwg_pkg::TicksW-1:0] total;
  logic [dtwg_pkg::TicksW-1:0] ticks_dec;
  logic [dtwg_pkg::SampleW-1:0] tone_sample;
  logic [dtwg_pkg::PhaseW:0]   row_sum, col_sum;
  logic [dtwg_pkg::PhaseW-1:0] row_next, col_next;

  localparam logic [dtwg_pkg::PhaseW:0] TableSizeW = (dtwg_pkg::PhaseW+1)'(dtwg_pkg::TableSize);

  assign dec        = dtwg_pkg::decode_key(item_i.key_char);
  assign total_full = (dtwg_pkg::TicksW+1)'(item_i.duration_ms) *
                      (dtwg_pkg::TicksW+1)'(tpm_i);
  assign total      = total_full[dtwg_pkg::TicksW] ? dtwg_pkg::TicksMax
                                                   : total_full[dtwg_pkg::TicksW-1:0];
  assign ticks_dec  = (ticks_q != '0) ? (ticks_q - dtwg_pkg::TicksW'(1)) : ticks_q;

  assign tone_sample = dtwg_pkg::SampleW'(dtwg_pkg::sine_at(row_phase_q)) +
                       dtwg_pkg::SampleW'(dtwg_pkg::sine_at(col_phase_q));

  // phases stay below the table size, so one subtract wraps them
  assign row_sum  = (dtwg_pkg::PhaseW+1)'(row_phase_q) + (dtwg_pkg::PhaseW+1)'(row_step_q);
  assign col_sum  = (dtwg_pkg::PhaseW+1)'(col_phase_q) + (dtwg_pkg::PhaseW+1)'(col_step_q);
  assign row_next = (row_sum >= TableSizeW) ? dtwg_pkg::PhaseW'(row_sum - TableSizeW)
                                            : row_sum[dtwg_pkg::PhaseW-1:0];
  assign col_next = (col_sum >= TableSizeW) ? dtwg_pkg::PhaseW'(col_sum - TableSizeW)
                                            : col_sum[dtwg_pkg::PhaseW-1:0];

  always_comb begin
    row_phase_d = row_phase_q;
    col_phase_d = col_phase_q;
    row_step_d  = row_step_q;
    col_step_d  = col_step_q;
    ticks_d     = ticks_q;
    active_d    = active_q;
    res_o       = '0;
    res_o.r1    = '{sample: dtwg_pkg::RestLevel, is_rest: 1'b1, last: 1'b1};
    if (fire_i) begin
      if (item_i.opcode == dtwg_pkg::OP_START) begin
        if (dec.ok) begin
          row_step_d = dec.row_step;
          col_step_d = dec.col_step;
          ticks_d    = total;
          active_d   = (total != '0);
          if (total == '0) begin
            res_o.cnt = 2'd1;
            res_o.r0  = '{sample: dtwg_pkg::RestLevel, is_rest: 1'b1, last: 1'b1};
          end
        end
      end else if (active_q) begin
        row_phase_d = row_next;
        col_phase_d = col_next;
        ticks_d     = ticks_dec;
        res_o.r0    = '{sample: tone_sample, is_rest: 1'b0, last: (ticks_dec != '0)};
        if (ticks_dec == '0) begin
          active_d  = 1'b0;
          res_o.cnt = 2'd2;
        end else begin
          res_o.cnt = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_phase_q <= '0;
      col_phase_q <= '0;
      row_step_q  <= '0;
      col_step_q  <= '0;
      ticks_q     <= '0;
      active_q    <= 1'b0;
    end else begin
      row_phase_q <= row_phase_d;
      col_phase_q <= col_phase_d;
      row_step_q  <= row_step_d;
      col_step_q  <= col_step_d;
      ticks_q     <= ticks_d;
      active_q    <= active_d;
    end
  end

endmodule

[rtl/dtwg_res_fifo.sv]
// ----------------------------------------------------------------------------
// dtwg_res_fifo
// Small result queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
module dtwg_res_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dtwg_pkg::res_pair_t     push_i,
  output dtwg_pkg::fifo_status_t  status_o,
  dtwg_out_if.source              out_if
);

  dtwg_pkg::result_t mem [dtwg_pkg::ResDepth];

  logic [dtwg_pkg::ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [dtwg_pkg::ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [dtwg_pkg::ResCntW-1:0] count_q, count_d;
  logic                         pop;
  logic [dtwg_pkg::ResCntW:0]   need, have;

  assign pop = (count_q != '0) && out_if.ready;

  assign out_if.valid   = (count_q != '0);
  assign out_if.sample  = mem[rd_ptr_q].sample;
  assign out_if.is_rest = mem[rd_ptr_q].is_rest;
  assign out_if.last    = mem[rd_ptr_q].last;

  // room for two results once this cycle's pop is counted
  assign need = (dtwg_pkg::ResCntW+1)'(count_q) + (dtwg_pkg::ResCntW+1)'(2);
  assign have = (dtwg_pkg::ResCntW+1)'(dtwg_pkg::ResDepth) + (dtwg_pkg::ResCntW+1)'(pop);
  assign status_o.room2 = (need <= have);
  assign status_o.count = count_q;

  assign wr_ptr_d = wr_ptr_q + dtwg_pkg::ResPtrW'(push_i.cnt);
  assign rd_ptr_d = rd_ptr_q + dtwg_pkg::ResPtrW'(pop);
  assign count_d  = count_q + dtwg_pkg::ResCntW'(push_i.cnt) - dtwg_pkg::ResCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_ptr_q + dtwg_pkg::ResPtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[rtl/dtwg_cfg_reg.sv]
// ----------------------------------------------------------------------------
// dtwg_cfg_reg
// Ticks-per-millisecond configuration register.
// ----------------------------------------------------------------------------
module dtwg_cfg_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dtwg_cfg_if.sink                   cfg_if,
  output logic [dtwg_pkg::TpmW-1:0]  tpm_o
);

  logic [dtwg_pkg::TpmW-1:0] tpm_q;

  assign cfg_if.ready = 1'b1;
  assign tpm_o        = tpm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= dtwg_pkg::TicksPerMsRst;
    end else if (cfg_if.valid) begin
      tpm_q <= cfg_if.data;
    end
  end

endmodule

[rtl/dtwg_wavetable_tone_generator.sv]
// ----------------------------------------------------------------------------
// dtmf_wavetable_tone_generator
// DTMF tone generator with two wavetable phase accumulators.
// ----------------------------------------------------------------------------
// Items on in_if are either a sample tick or a tone start carrying an ASCII
// key and a duration in ms. A valid key arms a tone of duration * ticks_per_ms
// ticks; every tick during the tone gives one sample on out_if, the sum of
// two sine table entries. The final tick also gives the rest level 126 with
// is_rest and last set. A start with zero length gives the rest result at
// once; bad keys and idle ticks give nothing.
// cfg_if writes ticks_per_ms (reset value 10); it is always ready.
// An accepted item is registered and is processed once the result queue
// has room for two results; its results reach out_if through that queue.
// Throughput: one item per cycle while the queue has that room, set by the
// single process stage; the output side drains one result per cycle, so
// final ticks with two results slow the input when the queue fills.
// When out_if stalls, the four-entry result queue fills and then in_if
// drops ready; nothing is lost. Reset idles the tone, clears both phases
// and steps and empties the queue.
// ----------------------------------------------------------------------------
module dtmf_wavetable_tone_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtwg_in_if.sink      in_if,
  dtwg_out_if.source   out_if,
  dtwg_cfg_if.sink     cfg_if
);

  logic                       in_valid_q;
  dtwg_pkg::item_t            in_item_q;
  logic                       proc_fire;
  logic [dtwg_pkg::TpmW-1:0]  tpm;
  dtwg_pkg::res_pair_t        res;
  dtwg_pkg::fifo_status_t     fifo_st;

  assign proc_fire   = in_valid_q && fifo_st.room2;
  assign in_if.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q <= '{opcode:      dtwg_pkg::opcode_e'(in_if.opcode),
                     key_char:    in_if.key_char,
                     duration_ms: in_if.duration_ms};
    end
  end

  dtwg_cfg_reg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_if),
    .tpm_o  (tpm)
  );

  dtwg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .item_i (in_item_q),
    .tpm_i  (tpm),
    .res_o  (res)
  );

  dtwg_res_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (res),
    .status_o (fifo_st),
    .out_if   (out_if)
  );

  // a held item is not dropped while the queue is full
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> in_valid_q)
    else $error("pending item lost");

  // results only come from a processed item
  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.cnt != 2'd0) |-> proc_fire)
    else $error("result without processed item");

  // the second of a pair is always the closing rest result
  a_pair_ends_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.cnt == 2'd2) |-> (res.r1.is_rest && res.r1.last && !res.r0.last))
    else $error("bad final tick pair");

  // queue never overflows
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_st.count <= dtwg_pkg::ResCntW'(dtwg_pkg::ResDepth))
    else $error("result queue overflow");

endmodule
